>>> sv/sle_pkg.sv
// Shared types, sizes and codes for the static list engine.
// Used by the cell, the controller, the top level and the checker; depends on nothing.
`default_nettype none

package sle_pkg;

	// List size and element width.
	localparam int LIST_CAPACITY = 32;
	localparam int ELEM_W        = 32;
	localparam int IDX_W         = (LIST_CAPACITY > 1) ? $clog2(LIST_CAPACITY) : 1;
	localparam int CNT_W         = $clog2(LIST_CAPACITY + 1);

	// Field widths of the stream beats.
	localparam int ACT_W  = 4;
	localparam int POS_W  = 6;
	localparam int FIDX_W = 5;
	localparam int LEN_W  = 6;
	localparam int STAT_W = 2;

	// Width that holds both a position and a count for comparisons.
	localparam int CMP_W = (CNT_W > POS_W) ? CNT_W : POS_W;

	// Input tdata layout.
	localparam int IN_VALUE_LSB = 0;
	localparam int IN_POS_LSB   = IN_VALUE_LSB + ELEM_W;
	localparam int S_TDATA_W    = ((IN_POS_LSB + POS_W + 7) / 8) * 8;

	// Output tdata layout.
	localparam int OUT_REM_LSB   = 0;
	localparam int OUT_FOUND_LSB = OUT_REM_LSB + ELEM_W;
	localparam int OUT_FIDX_LSB  = OUT_FOUND_LSB + 1;
	localparam int OUT_MAX_LSB   = OUT_FIDX_LSB + FIDX_W;
	localparam int OUT_MIN_LSB   = OUT_MAX_LSB + ELEM_W;
	localparam int OUT_LEN_LSB   = OUT_MIN_LSB + ELEM_W;
	localparam int OUT_STAT_LSB  = OUT_LEN_LSB + LEN_W;
	localparam int OUT_USED_W    = OUT_STAT_LSB + STAT_W;
	localparam int M_TDATA_W     = ((OUT_USED_W + 7) / 8) * 8;

	typedef logic signed [ELEM_W-1:0] elem_t;

	typedef enum logic [ACT_W-1:0] {
		ACT_INS_FIRST = 4'd0,
		ACT_INS_AT    = 4'd1,
		ACT_INS_LAST  = 4'd2,
		ACT_DEL_FIRST = 4'd3,
		ACT_DEL_AT    = 4'd4,
		ACT_DEL_LAST  = 4'd5,
		ACT_FIND      = 4'd6,
		ACT_EXTREMES  = 4'd7,
		ACT_SORT_ASC  = 4'd8,
		ACT_SORT_DESC = 4'd9
	} action_t;

	typedef enum logic [STAT_W-1:0] {
		STATUS_OK    = 2'd0,
		STATUS_FULL  = 2'd1,
		STATUS_EMPTY = 2'd2,
		STATUS_POS   = 2'd3
	} status_t;

	// What every cell does in a cycle.
	typedef enum logic [2:0] {
		CM_HOLD,
		CM_INSERT,
		CM_DELETE,
		CM_ROTATE,
		CM_SORT
	} cell_mode_t;

	typedef struct packed {
		cell_mode_t       mode;
		logic [IDX_W-1:0] pos;
		elem_t            value;
		logic [CNT_W-1:0] count;
		logic             odd_phase;
		logic             ascending;
	} cell_ctrl_t;

	// Controller sequencing states.
	typedef enum logic [1:0] {
		FSM_IDLE,
		FSM_SCAN,
		FSM_SORT
	} state_t;

	typedef struct packed {
		elem_t             removed;
		logic              found;
		logic [FIDX_W-1:0] found_index;
		elem_t             max_value;
		elem_t             min_value;
		logic [LEN_W-1:0]  list_length;
		status_t           status;
	} res_t;

endpackage

`default_nettype wire

>>> sv/static_list_engine.sv
// Top level of the static list engine: a ring of element cells and their controller.
// Depends on sle_pkg, sle_cell and sle_ctrl.
//
// The block keeps a packed list of up to LIST_CAPACITY signed 32-bit elements and runs one
// operation per input beat: insert or delete at the front, at a position or at the end, find,
// extremes, or sort. Inserts, deletes, error cases, unused action codes and a find or extremes
// on an empty list are answered straight from the idle state. Find and extremes rotate the
// cell ring once around while cell zero is compared, and sorts run LIST_CAPACITY odd-even
// transposition phases across the cell pairs before the result is loaded. A finished result
// waits in the output register, and no new beat is taken while it is held back; a new beat
// enters only when the block is idle and the output register is empty or drains in the same
// cycle. The elements are not cleared by reset; only the count, state and output valid are.
`default_nettype none

module static_list_engine (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          s_tvalid,
	output logic                               s_tready,
	// value [31:0], position [37:32], zero fill above
	input  wire logic [sle_pkg::S_TDATA_W-1:0] s_tdata,
	// action [3:0]
	input  wire logic [sle_pkg::ACT_W-1:0]     s_tuser,
	output logic                               m_tvalid,
	input  wire logic                          m_tready,
	// removed_value [31:0], found [32], found_index [37:33], max_value [69:38],
	// min_value [101:70], list_length [107:102], status [109:108], zero fill above
	output logic [sle_pkg::M_TDATA_W-1:0]      m_tdata
);
	import sle_pkg::*;

	elem_t      cells [LIST_CAPACITY];
	logic       bad   [LIST_CAPACITY];
	cell_ctrl_t cell_ctrl;
	res_t       res;

	sle_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tuser   (s_tuser),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.res       (res),
		.cells     (cells),
		.cell_ctrl (cell_ctrl)
	);

	// Cell ring: each cell sees its neighbors, the last wraps to the first.
	for (genvar k = 0; k < LIST_CAPACITY; k++) begin : g_cell
		sle_cell u_cell (
			.clk      (clk),
			.ctrl     (cell_ctrl),
			.idx      (IDX_W'(k)),
			.left     (cells[(k + LIST_CAPACITY - 1) % LIST_CAPACITY]),
			.right    (cells[(k + 1) % LIST_CAPACITY]),
			.left_bad (bad[(k + LIST_CAPACITY - 1) % LIST_CAPACITY]),
			.value    (cells[k]),
			.bad      (bad[k])
		);
	end

	// Result beat packing.
	always_comb begin
		m_tdata = '0;
		m_tdata[OUT_REM_LSB   +: ELEM_W] = res.removed;
		m_tdata[OUT_FOUND_LSB]           = res.found;
		m_tdata[OUT_FIDX_LSB  +: FIDX_W] = res.found_index;
		m_tdata[OUT_MAX_LSB   +: ELEM_W] = res.max_value;
		m_tdata[OUT_MIN_LSB   +: ELEM_W] = res.min_value;
		m_tdata[OUT_LEN_LSB   +: LEN_W]  = res.list_length;
		m_tdata[OUT_STAT_LSB  +: STAT_W] = res.status;
	end

endmodule

`default_nettype wire

>>> sv/sle_cell.sv
// One storage cell of the list chain: holds one element and trades it with its neighbors.
// Depends on sle_pkg for the element type and the broadcast control struct.
`default_nettype none

module sle_cell (
	input  wire logic                      clk,
	input  wire sle_pkg::cell_ctrl_t       ctrl,
	input  wire logic [sle_pkg::IDX_W-1:0] idx,
	input  wire sle_pkg::elem_t            left,
	input  wire sle_pkg::elem_t            right,
	input  wire logic                      left_bad,
	output sle_pkg::elem_t                 value,
	output logic                           bad
);
	import sle_pkg::*;

	elem_t            value_q;
	elem_t            value_d;
	logic [CNT_W-1:0] idx_c;
	logic             lower;
	logic             act_lower;
	logic             act_upper;

	assign idx_c = CNT_W'(idx);
	assign value = value_q;

	// Out of order with the right neighbor for the chosen sort direction.
	assign bad = ctrl.ascending ? (value_q > right) : (value_q < right);

	// In this phase the cell is either the lower or the upper half of a pair.
	assign lower     = (idx[0] == ctrl.odd_phase);
	assign act_lower = lower && ((idx_c + CNT_W'(1)) < ctrl.count);
	assign act_upper = !lower && (idx != '0) && (idx_c < ctrl.count);

	// Next element of this cell.
	always_comb begin
		value_d = value_q;
		case (ctrl.mode)
			CM_INSERT: begin
				if (idx == ctrl.pos) begin
					value_d = ctrl.value;
				end else if (idx > ctrl.pos) begin
					value_d = left;
				end
			end
			CM_DELETE: begin
				if (idx >= ctrl.pos) begin
					value_d = right;
				end
			end
			CM_ROTATE: begin
				value_d = right;
			end
			CM_SORT: begin
				if (act_lower && bad) begin
					value_d = right;
				end else if (act_upper && left_bad) begin
					value_d = left;
				end
			end
			default: begin
				value_d = value_q;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		value_q <= value_d;
	end

endmodule

`default_nettype wire

>>> sv/sle_ctrl.sv
// Controller of the list engine: decodes beats, sequences scans and sorts, holds the count
// and the output register. Depends on sle_pkg; drives the cell chain through cell_ctrl_t.
`default_nettype none

module sle_ctrl (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          s_tvalid,
	output logic                               s_tready,
	input  wire logic [sle_pkg::S_TDATA_W-1:0] s_tdata,
	input  wire logic [sle_pkg::ACT_W-1:0]     s_tuser,
	output logic                               m_tvalid,
	input  wire logic                          m_tready,
	output sle_pkg::res_t                      res,
	input  wire sle_pkg::elem_t                cells [sle_pkg::LIST_CAPACITY],
	output sle_pkg::cell_ctrl_t                cell_ctrl
);
	import sle_pkg::*;

	localparam logic [IDX_W-1:0] LAST_STEP = IDX_W'(LIST_CAPACITY - 1);
	localparam logic [CNT_W-1:0] FULL_CNT  = CNT_W'(LIST_CAPACITY);

	state_t           state_q, state_d;
	logic [IDX_W-1:0] step_q;
	logic [CNT_W-1:0] count_q, count_d;
	logic             is_find_q, asc_q;
	elem_t            search_q;
	logic             found_q, found_d;
	logic [IDX_W-1:0] fidx_q, fidx_d;
	elem_t            max_q, max_d, min_q, min_d;
	logic             m_tvalid_q;
	res_t             res_q, res_d;
	logic             load_res, go_scan, go_sort, last_step;

	action_t          action;
	elem_t            in_value;
	logic [POS_W-1:0] in_pos;
	logic             accept;
	logic [CMP_W-1:0] count_x, ins_pos, del_pos;
	logic             hit, step_valid;
	elem_t            head;

	assign action   = action_t'(s_tuser);
	assign in_value = s_tdata[IN_VALUE_LSB +: ELEM_W];
	assign in_pos   = s_tdata[IN_POS_LSB +: POS_W];

	assign s_tready = (state_q == FSM_IDLE) && (!m_tvalid_q || m_tready);
	assign accept   = s_tvalid && s_tready;
	assign m_tvalid = m_tvalid_q;
	assign res      = res_q;

	assign count_x   = CMP_W'(count_q);
	assign last_step = (step_q == LAST_STEP);

	// Positions for the edge variants of insert and delete.
	always_comb begin
		case (action)
			ACT_INS_FIRST: ins_pos = '0;
			ACT_INS_LAST:  ins_pos = count_x;
			default:       ins_pos = CMP_W'(in_pos);
		endcase
		case (action)
			ACT_DEL_FIRST: del_pos = '0;
			ACT_DEL_LAST:  del_pos = count_x - CMP_W'(1);
			default:       del_pos = CMP_W'(in_pos);
		endcase
	end

	// Scan accumulators: cell zero shows element step_q while the ring rotates.
	assign head       = cells[0];
	assign step_valid = (CNT_W'(step_q) < count_q);
	assign hit        = is_find_q && step_valid && !found_q && (head == search_q);

	always_comb begin
		found_d = found_q || hit;
		fidx_d  = hit ? step_q : fidx_q;
		max_d   = max_q;
		min_d   = min_q;
		if (step_q == '0) begin
			max_d = head;
			min_d = head;
		end else if (step_valid) begin
			if (head > max_q) begin
				max_d = head;
			end
			if (head < min_q) begin
				min_d = head;
			end
		end
	end

	// Next state.
	always_comb begin
		state_d = state_q;
		case (state_q)
			FSM_IDLE: begin
				if (go_scan) begin
					state_d = FSM_SCAN;
				end else if (go_sort) begin
					state_d = FSM_SORT;
				end
			end
			FSM_SCAN, FSM_SORT: begin
				if (last_step) begin
					state_d = FSM_IDLE;
				end
			end
			default: begin
				state_d = FSM_IDLE;
			end
		endcase
	end

	// Cell commands, results and count updates.
	always_comb begin
		cell_ctrl.mode      = CM_HOLD;
		cell_ctrl.pos       = ins_pos[IDX_W-1:0];
		cell_ctrl.value     = in_value;
		cell_ctrl.count     = count_q;
		cell_ctrl.odd_phase = step_q[0];
		cell_ctrl.ascending = asc_q;
		count_d  = count_q;
		load_res = 1'b0;
		go_scan  = 1'b0;
		go_sort  = 1'b0;
		res_d    = '0;
		res_d.status = STATUS_OK;
		case (state_q)
			FSM_IDLE: begin
				if (accept) begin
					case (action)
						ACT_INS_FIRST, ACT_INS_AT, ACT_INS_LAST: begin
							load_res = 1'b1;
							if (count_q >= FULL_CNT) begin
								res_d.status = STATUS_FULL;
							end else if (ins_pos > count_x) begin
								res_d.status = STATUS_POS;
							end else begin
								cell_ctrl.mode = CM_INSERT;
								count_d = count_q + CNT_W'(1);
							end
						end
						ACT_DEL_FIRST, ACT_DEL_AT, ACT_DEL_LAST: begin
							load_res = 1'b1;
							cell_ctrl.pos = del_pos[IDX_W-1:0];
							if (count_q == '0) begin
								res_d.status = STATUS_EMPTY;
							end else if (del_pos >= count_x) begin
								res_d.status = STATUS_POS;
							end else begin
								cell_ctrl.mode = CM_DELETE;
								res_d.removed = cells[del_pos[IDX_W-1:0]];
								count_d = count_q - CNT_W'(1);
							end
						end
						ACT_FIND: begin
							if (count_q == '0) begin
								load_res = 1'b1;
							end else begin
								go_scan = 1'b1;
							end
						end
						ACT_EXTREMES: begin
							if (count_q == '0) begin
								load_res = 1'b1;
								res_d.status = STATUS_EMPTY;
							end else begin
								go_scan = 1'b1;
							end
						end
						ACT_SORT_ASC, ACT_SORT_DESC: begin
							go_sort = 1'b1;
						end
						default: begin
							load_res = 1'b1;
						end
					endcase
				end
			end
			FSM_SCAN: begin
				cell_ctrl.mode = CM_ROTATE;
				if (last_step) begin
					load_res = 1'b1;
					if (is_find_q) begin
						res_d.found       = found_d;
						res_d.found_index = FIDX_W'(fidx_d);
					end else begin
						res_d.max_value = max_d;
						res_d.min_value = min_d;
					end
				end
			end
			FSM_SORT: begin
				cell_ctrl.mode = CM_SORT;
				load_res = last_step;
			end
			default: begin
				cell_ctrl.mode = CM_HOLD;
			end
		endcase
		res_d.list_length = LEN_W'(count_d);
	end

	// Control registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= FSM_IDLE;
			step_q     <= '0;
			count_q    <= '0;
			m_tvalid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			count_q <= count_d;
			if (state_q == FSM_IDLE) begin
				step_q <= '0;
			end else begin
				step_q <= step_q + IDX_W'(1);
			end
			if (load_res) begin
				m_tvalid_q <= 1'b1;
			end else if (m_tready) begin
				m_tvalid_q <= 1'b0;
			end
		end
	end

	// Payload registers.
	always_ff @(posedge clk) begin
		if (accept) begin
			is_find_q <= (action == ACT_FIND);
			asc_q     <= (action == ACT_SORT_ASC);
			search_q  <= in_value;
		end
		if (state_q == FSM_IDLE) begin
			found_q <= 1'b0;
			fidx_q  <= '0;
		end else begin
			found_q <= found_d;
			fidx_q  <= fidx_d;
		end
		max_q <= max_d;
		min_q <= min_d;
		if (load_res) begin
			res_q <= res_d;
		end
	end

endmodule

`default_nettype wire

>>> sv/sle_checker.sv
// Port-level checks for the static list engine, attached by the bind at the end.
// Depends on sle_pkg for field offsets, sizes and status codes.
`default_nettype none

module sle_checker (
	input wire logic                          clk,
	input wire logic                          arst_n,
	input wire logic                          s_tvalid,
	input wire logic                          s_tready,
	input wire logic [sle_pkg::S_TDATA_W-1:0] s_tdata,
	input wire logic [sle_pkg::ACT_W-1:0]     s_tuser,
	input wire logic                          m_tvalid,
	input wire logic                          m_tready,
	input wire logic [sle_pkg::M_TDATA_W-1:0] m_tdata
);
	import sle_pkg::*;

	logic [LEN_W-1:0]  len;
	logic [STAT_W-1:0] stat;

	assign len  = m_tdata[OUT_LEN_LSB +: LEN_W];
	assign stat = m_tdata[OUT_STAT_LSB +: STAT_W];

	// A result beat that is held back keeps new input beats out.
	a_no_accept_on_stall: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |-> !s_tready)
		else $error("input beat taken while a result beat is stalled");

	// A stalled result beat holds its data.
	a_stall_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
		else $error("stalled result beat changed");

	// A full report comes only with a full list.
	a_full_len: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && (stat == STATUS_FULL) |-> (len == LEN_W'(LIST_CAPACITY)))
		else $error("full status with a list that is not full");

	// An empty report comes with no elements and nothing removed.
	a_empty_len: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && (stat == STATUS_EMPTY) |->
			(len == '0) && (m_tdata[OUT_REM_LSB +: ELEM_W] == '0))
		else $error("empty status with elements or a removed value");

endmodule

bind static_list_engine sle_checker u_sle_checker (.*);

`default_nettype wire
